@@ hw/rtl/dwrq_pkg.sv @@
// Shared constants, types and helpers for the deferred work ring queue.
`default_nettype none

package dwrq_pkg;

  localparam int unsigned QUEUE_SLOTS = 256;
  localparam int unsigned PTR_W       = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned ENTRY_W     = 2 * WORD_W;
  localparam int unsigned STAT_W      = 32;
  localparam int unsigned DEPTH_W     = 8;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [2:0] {
    ST_PUSHED  = 3'd0,
    ST_DROPPED = 3'd1,
    ST_IGNORED = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // Advance a ring pointer, wrapping at the last slot.
  function automatic ptr_t ptr_next(input ptr_t p);
    if (p == ptr_t'(QUEUE_SLOTS - 1)) begin
      return '0;
    end
    return p + ptr_t'(1);
  endfunction

  // Clamp an entry count to the 8-bit depth fields.
  function automatic logic [DEPTH_W-1:0] sat_depth(input ptr_t c);
    logic [PTR_W+DEPTH_W-1:0] wide;
    wide = {{DEPTH_W{1'b0}}, c};
    if (wide > (PTR_W + DEPTH_W)'(255)) begin
      return {DEPTH_W{1'b1}};
    end
    return wide[DEPTH_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dwrq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module dwrq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/deferred_work_ring_queue.sv @@
// Deferred work ring queue: top level with entry RAM, pointers and statistics.
//
// Input channel (in_valid_i/in_ready_o) carries one request: operation_i
// selects push (0) or pop (1); handler_i and argument_i form the entry.
// Output channel (out_valid_o/out_ready_i) returns one result per request:
// status, the popped entry (zero otherwise), depth after the request and
// the four statistics (queued, dropped, ran, high water).
// The ring holds QUEUE_SLOTS-1 entries in one RAM of handler and argument
// words; a zero handler is ignored and a push into a full ring is dropped.
// A push, an ignored push, a dropped push or an empty pop gives its result
// in the cycle after acceptance. A pop that finds an entry gives its result
// through the RAM read register and then the output register (state S_READ).
// Throughput: one push per cycle while each result is taken; a successful pop
// stops the queue taking requests while the RAM read is in flight.
// A new request is taken in the same cycle the previous result is taken.
// Reset clears pointers, counters and the peak; RAM contents are not
// cleared and no entry is read before it is written.
// When the receiver stalls, the result stays in the output register and
// in_ready_o stays low until it is taken.
`default_nettype none

module deferred_work_ring_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [63:0] handler_i,
  input  wire logic [63:0] argument_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [63:0]      out_handler_o,
  output logic [63:0]      out_argument_o,
  output logic [7:0]       current_depth_o,
  output logic [31:0]      queued_count_o,
  output logic [31:0]      dropped_count_o,
  output logic [31:0]      ran_count_o,
  output logic [7:0]       high_water_o
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e                        state_q;
  dwrq_pkg::ptr_t                rd_ptr_q;
  dwrq_pkg::ptr_t                wr_ptr_q;
  dwrq_pkg::ptr_t                count_q;
  logic [dwrq_pkg::STAT_W-1:0]   queued_q;
  logic [dwrq_pkg::STAT_W-1:0]   dropped_q;
  logic [dwrq_pkg::STAT_W-1:0]   ran_q;
  logic [dwrq_pkg::DEPTH_W-1:0]  peak_q;

  logic                          out_valid_q;
  dwrq_pkg::status_e             out_status_q;
  logic [dwrq_pkg::WORD_W-1:0]   out_handler_q;
  logic [dwrq_pkg::WORD_W-1:0]   out_argument_q;
  logic [dwrq_pkg::DEPTH_W-1:0]  out_depth_q;

  logic                          accept;
  logic                          is_pop;
  logic                          full;
  logic                          empty;
  logic                          do_push;
  logic                          do_pop;
  dwrq_pkg::ptr_t                count_push;
  dwrq_pkg::ptr_t                count_pop;
  logic [dwrq_pkg::DEPTH_W-1:0]  depth_push;
  logic [dwrq_pkg::ENTRY_W-1:0]  ram_rdata;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_pop     = (operation_i == dwrq_pkg::OP_POP);
  assign full       = (count_q == dwrq_pkg::ptr_t'(dwrq_pkg::QUEUE_SLOTS - 1));
  assign empty      = (count_q == '0);
  assign do_push    = accept && !is_pop && (handler_i != '0) && !full;
  assign do_pop     = accept && is_pop && !empty;
  assign count_push = count_q + dwrq_pkg::ptr_t'(1);
  assign count_pop  = count_q - dwrq_pkg::ptr_t'(1);
  assign depth_push = dwrq_pkg::sat_depth(count_push);

  dwrq_ram #(
    .WIDTH (dwrq_pkg::ENTRY_W),
    .DEPTH (dwrq_pkg::QUEUE_SLOTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (wr_ptr_q),
    .wdata_i ({handler_i, argument_i}),
    .re_i    (do_pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      rd_ptr_q       <= '0;
      wr_ptr_q       <= '0;
      count_q        <= '0;
      queued_q       <= '0;
      dropped_q      <= '0;
      ran_q          <= '0;
      peak_q         <= '0;
      out_valid_q    <= 1'b0;
      out_status_q   <= dwrq_pkg::ST_EMPTY;
      out_handler_q  <= '0;
      out_argument_q <= '0;
      out_depth_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_handler_q  <= '0;
            out_argument_q <= '0;
            // hold the result back until the RAM word arrives
            out_valid_q    <= !do_pop;
            if (is_pop) begin
              if (empty) begin
                out_status_q <= dwrq_pkg::ST_EMPTY;
                out_depth_q  <= dwrq_pkg::sat_depth(count_q);
              end else begin
                out_status_q <= dwrq_pkg::ST_POPPED;
                out_depth_q  <= dwrq_pkg::sat_depth(count_pop);
                rd_ptr_q     <= dwrq_pkg::ptr_next(rd_ptr_q);
                count_q      <= count_pop;
                ran_q        <= ran_q + dwrq_pkg::STAT_W'(1);
                state_q      <= S_READ;
              end
            end else if (handler_i == '0) begin
              out_status_q <= dwrq_pkg::ST_IGNORED;
              out_depth_q  <= dwrq_pkg::sat_depth(count_q);
            end else if (full) begin
              out_status_q <= dwrq_pkg::ST_DROPPED;
              out_depth_q  <= dwrq_pkg::sat_depth(count_q);
              dropped_q    <= dropped_q + dwrq_pkg::STAT_W'(1);
            end else begin
              out_status_q <= dwrq_pkg::ST_PUSHED;
              out_depth_q  <= depth_push;
              wr_ptr_q     <= dwrq_pkg::ptr_next(wr_ptr_q);
              count_q      <= count_push;
              queued_q     <= queued_q + dwrq_pkg::STAT_W'(1);
              if (depth_push > peak_q) begin
                peak_q <= depth_push;
              end
            end
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_READ: begin
          out_handler_q  <= ram_rdata[dwrq_pkg::ENTRY_W-1:dwrq_pkg::WORD_W];
          out_argument_q <= ram_rdata[dwrq_pkg::WORD_W-1:0];
          out_valid_q    <= 1'b1;
          state_q        <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign out_handler_o   = out_handler_q;
  assign out_argument_o  = out_argument_q;
  assign current_depth_o = out_depth_q;
  assign queued_count_o  = queued_q;
  assign dropped_count_o = dropped_q;
  assign ran_count_o     = ran_q;
  assign high_water_o    = peak_q;

  // The ring never fills its spare slot.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dwrq_pkg::ptr_t'(dwrq_pkg::QUEUE_SLOTS - 1))
    else $error("entry count exceeds ring capacity");

  // The output register is free while a RAM read is in flight.
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !out_valid_q)
    else $error("result pending during RAM read");

  // Only entries with a nonzero handler are stored, so a pop never returns zero.
  a_pop_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == dwrq_pkg::ST_POPPED)) |-> (out_handler_q != '0))
    else $error("popped entry has a zero handler");

  // The reported depth never exceeds the peak.
  a_depth_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_depth_q <= peak_q))
    else $error("depth above peak");

endmodule

`default_nettype wire
